// ===== design/atsc_pkg.sv =====
package atsc_pkg;

	// Field widths fixed by the interface
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	localparam int ADDR_W = 5;
	localparam int IDX_W  = ADDR_W - 2;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [PROD_W-1:0] prod_t;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_STEP_KIND     = 3'd0;
	localparam logic [IDX_W-1:0] REG_GROW_AMOUNT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_SHRINK_AMOUNT = 3'd2;
	localparam logic [IDX_W-1:0] REG_BAND_MARGIN   = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEP_FLOOR    = 3'd4;
	localparam logic [IDX_W-1:0] REG_STEP_CEILING  = 3'd5;

	// Step change kinds; other codes are undefined
	localparam logic [1:0] KIND_GEO = 2'd0;
	localparam logic [1:0] KIND_ARI = 2'd1;

	// Grades ranked so that a lower code is a worse grade
	typedef enum logic [2:0] {
		GR_RERUN = 3'd0,
		GR_CUT   = 3'd1,
		GR_KEEP  = 3'd2,
		GR_INC   = 3'd3,
		GR_NONE  = 3'd4
	} grade_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_MIN   = 3'd1,
		ST_MAX   = 3'd2,
		ST_UNDEF = 3'd3,
		ST_FATAL = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ACT_KEEP  = 2'd0,
		ACT_INC   = 2'd1,
		ACT_CUT   = 2'd2,
		ACT_RERUN = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0] kind;
		data_t      grow;
		data_t      shrink;
		data_t      margin;
		data_t      floor_val;
		data_t      ceiling;
	} cfg_t;

	typedef struct packed {
		data_t   new_step;
		logic    accepted;
		status_t status;
		action_t action;
	} res_t;

endpackage

// ===== design/adaptive_time_step_control_unit.sv =====
// Channel   Handshake                   Payload
// item      item_valid / item_ready     criterion_present, variation, keep_reference,
//                                       rerun_limit, current_step, last_criterion
// result    result_valid / result_ready new_step, step_accepted, status, step_action
// config    psel/penable/pwrite, pready paddr, pwdata, prdata
//
// One item per cycle while no waiting result holds a last item. An item passes
// through the input register and then the product register (four 32x32
// multiplies), and a last item's result is then loaded into the output register.
// Grading and the worst-grade update happen as an item leaves the product register.
// A waiting result stalls only a last item; at most one further item is taken behind it.
// Reset loads the register defaults and clears the worst grade; no clearing pass.
module adaptive_time_step_control_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [atsc_pkg::ADDR_W-1:0]       paddr,
	input  atsc_pkg::data_t                   pwdata,
	output atsc_pkg::data_t                   prdata,
	output logic                              pready,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic                              criterion_present,
	input  atsc_pkg::data_t                   variation,
	input  atsc_pkg::data_t                   keep_reference,
	input  atsc_pkg::data_t                   rerun_limit,
	input  atsc_pkg::data_t                   current_step,
	input  logic                              last_criterion,
	output logic                              result_valid,
	input  logic                              result_ready,
	output atsc_pkg::data_t                   new_step,
	output logic                              step_accepted,
	output logic [2:0]                        status,
	output logic [1:0]                        step_action
);
	import atsc_pkg::*;

	cfg_t             cfg_q;
	logic [IDX_W-1:0] reg_idx;
	logic             cfg_wr;

	logic             v_s1;
	logic             present_s1;
	logic             last_s1;
	data_t            dx_s1;
	data_t            r1_s1;
	data_t            r2_s1;
	data_t            step_s1;

	logic             v_s2;
	logic             present_s2;
	logic             last_s2;
	data_t            dx_s2;
	data_t            r1_s2;
	data_t            r2_s2;
	data_t            step_s2;
	prod_t            pm_s2;
	prod_t            rm_s2;
	prod_t            gp_s2;
	prod_t            sp_s2;

	grade_t           worst_q;
	grade_t           grade;
	grade_t           worst_nxt;
	res_t             res;
	res_t             res_q;
	logic             res_valid_q;

	logic             out_free;
	logic             s2_move;
	logic             s2_free;
	logic             s1_move;
	logic             s1_free;
	logic             item_take;

	// Configuration port
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind      <= KIND_GEO;
			cfg_q.grow      <= 32'd81920;
			cfg_q.shrink    <= 32'd32768;
			cfg_q.margin    <= 32'd6554;
			cfg_q.floor_val <= 32'd1;
			cfg_q.ceiling   <= 32'hFFFF_FFFF;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_STEP_KIND:     cfg_q.kind      <= pwdata[1:0];
				REG_GROW_AMOUNT:   cfg_q.grow      <= pwdata;
				REG_SHRINK_AMOUNT: cfg_q.shrink    <= pwdata;
				REG_BAND_MARGIN:   cfg_q.margin    <= pwdata;
				REG_STEP_FLOOR:    cfg_q.floor_val <= pwdata;
				REG_STEP_CEILING:  cfg_q.ceiling   <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (reg_idx)
			REG_STEP_KIND:     prdata = DATA_W'(cfg_q.kind);
			REG_GROW_AMOUNT:   prdata = cfg_q.grow;
			REG_SHRINK_AMOUNT: prdata = cfg_q.shrink;
			REG_BAND_MARGIN:   prdata = cfg_q.margin;
			REG_STEP_FLOOR:    prdata = cfg_q.floor_val;
			REG_STEP_CEILING:  prdata = cfg_q.ceiling;
			default:           prdata = '0;
		endcase
	end

	// Flow control: a stage moves when the next is free; only a last item waits on output
	assign out_free   = !res_valid_q || result_ready;
	assign s2_move    = v_s2 && (!last_s2 || out_free);
	assign s2_free    = !v_s2 || s2_move;
	assign s1_move    = v_s1 && s2_free;
	assign s1_free    = !v_s1 || s2_free;
	assign item_ready = s1_free;
	assign item_take  = item_valid && s1_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= item_take;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			present_s1 <= criterion_present;
			last_s1    <= last_criterion;
			dx_s1      <= variation;
			r1_s1      <= keep_reference;
			r2_s1      <= rerun_limit;
			step_s1    <= current_step;
		end
	end

	// Product register: band products and both candidate step products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= s1_move;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			present_s2 <= present_s1;
			last_s2    <= last_s1;
			dx_s2      <= dx_s1;
			r1_s2      <= r1_s1;
			r2_s2      <= r2_s1;
			step_s2    <= step_s1;
			pm_s2      <= PROD_W'(dx_s1) * PROD_W'(cfg_q.margin);
			rm_s2      <= PROD_W'(r1_s1) * PROD_W'(cfg_q.margin);
			gp_s2      <= PROD_W'(step_s1) * PROD_W'(cfg_q.grow);
			sp_s2      <= PROD_W'(step_s1) * PROD_W'(cfg_q.shrink);
		end
	end

	atsc_grade #(
		.FRAC_BITS (FRAC_BITS)
	) u_grade (
		.dx    (dx_s2),
		.r1    (r1_s2),
		.r2    (r2_s2),
		.pm    (pm_s2),
		.rm    (rm_s2),
		.grade (grade)
	);

	// Fold this criterion into the worst grade of the time step
	assign worst_nxt = (present_s2 && (grade < worst_q)) ? grade : worst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			worst_q <= GR_NONE;
		end else if (s2_move) begin
			worst_q <= last_s2 ? GR_NONE : worst_nxt;
		end
	end

	atsc_step #(
		.FRAC_BITS (FRAC_BITS)
	) u_step (
		.cfg         (cfg_q),
		.worst       (worst_nxt),
		.step        (step_s2),
		.grow_prod   (gp_s2),
		.shrink_prod (sp_s2),
		.res         (res)
	);

	// Result register: load on a last item, drop once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s2_move && last_s2) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move && last_s2) begin
			res_q <= res;
		end
	end

	assign result_valid  = res_valid_q;
	assign new_step      = res_q.new_step;
	assign step_accepted = res_q.accepted;
	assign status        = res_q.status;
	assign step_action   = res_q.action;

endmodule

// ===== design/atsc_grade.sv =====
module atsc_grade #(
	parameter int FRAC_BITS = 16
) (
	input  atsc_pkg::data_t  dx,
	input  atsc_pkg::data_t  r1,
	input  atsc_pkg::data_t  r2,
	input  atsc_pkg::prod_t  pm,
	input  atsc_pkg::prod_t  rm,
	output atsc_pkg::grade_t grade
);
	import atsc_pkg::*;

	localparam prod_t FMASK = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);

	prod_t               pm_sh;
	prod_t               rm_sh;
	logic [PROD_W:0]     dxb;
	logic [PROD_W:0]     r1b;
	logic [PROD_W:0]     dx_w;
	logic [PROD_W:0]     r1_w;
	logic                r1b_frac;

	// Band products: floor(dx*(1+B)) against r1, and r1*(1+B) split into whole and fraction
	always_comb begin
		pm_sh    = pm >> FRAC_BITS;
		rm_sh    = rm >> FRAC_BITS;
		dx_w     = (PROD_W+1)'(dx);
		r1_w     = (PROD_W+1)'(r1);
		dxb      = {1'b0, pm_sh} + dx_w;
		r1b      = {1'b0, rm_sh} + r1_w;
		r1b_frac = |(rm & FMASK);
	end

	// Grade the criterion, best band first
	always_comb begin
		priority if (dxb < r1_w) begin
			grade = GR_INC;
		end else if (dx_w < r1b || (dx_w == r1b && r1b_frac)) begin
			grade = GR_KEEP;
		end else if (dx < r2) begin
			grade = GR_CUT;
		end else begin
			grade = GR_RERUN;
		end
	end

endmodule

// ===== design/atsc_step.sv =====
module atsc_step #(
	parameter int FRAC_BITS = 16
) (
	input  atsc_pkg::cfg_t   cfg,
	input  atsc_pkg::grade_t worst,
	input  atsc_pkg::data_t  step,
	input  atsc_pkg::prod_t  grow_prod,
	input  atsc_pkg::prod_t  shrink_prod,
	output atsc_pkg::res_t   res
);
	import atsc_pkg::*;

	prod_t           gp_sh;
	prod_t           sp_sh;
	data_t           grow_geo;
	data_t           cut_geo;
	logic [DATA_W:0] grow_sum;
	data_t           grow_ari;
	data_t           grow_val;
	data_t           cut_val;
	logic            cut_under;
	logic            cut_low;
	logic            kind_ok;

	// Candidate steps for both kinds, saturated at full scale
	always_comb begin
		gp_sh     = grow_prod >> FRAC_BITS;
		sp_sh     = shrink_prod >> FRAC_BITS;
		grow_geo  = (|gp_sh[PROD_W-1:DATA_W]) ? '1 : gp_sh[DATA_W-1:0];
		cut_geo   = (|sp_sh[PROD_W-1:DATA_W]) ? '1 : sp_sh[DATA_W-1:0];
		grow_sum  = {1'b0, step} + {1'b0, cfg.grow};
		grow_ari  = grow_sum[DATA_W] ? '1 : grow_sum[DATA_W-1:0];
		kind_ok   = (cfg.kind == KIND_GEO) || (cfg.kind == KIND_ARI);
		grow_val  = (cfg.kind == KIND_GEO) ? grow_geo : grow_ari;
		cut_under = (cfg.kind == KIND_ARI) && (cfg.shrink > step);
		cut_val   = (cfg.kind == KIND_GEO) ? cut_geo : (step - cfg.shrink);
		cut_low   = cut_under || (cut_val < cfg.floor_val);
	end

	// Pick the outcome from the worst grade of the time step
	always_comb begin
		res.new_step = step;
		res.accepted = 1'b1;
		res.status   = ST_OK;
		res.action   = ACT_KEEP;
		unique case (worst)
			GR_INC: begin
				res.action = ACT_INC;
				if (!kind_ok) begin
					res.status   = ST_UNDEF;
					res.accepted = 1'b0;
				end else if (grow_val > cfg.ceiling) begin
					res.new_step = cfg.ceiling;
					res.status   = ST_MAX;
				end else begin
					res.new_step = grow_val;
				end
			end
			GR_CUT: begin
				res.action = ACT_CUT;
				if (!kind_ok) begin
					res.status   = ST_UNDEF;
					res.accepted = 1'b0;
				end else if (cut_low) begin
					res.new_step = cfg.floor_val;
					res.status   = ST_MIN;
				end else begin
					res.new_step = cut_val;
				end
			end
			GR_RERUN: begin
				res.action   = ACT_RERUN;
				res.accepted = 1'b0;
				if (!kind_ok) begin
					res.status = ST_FATAL;
				end else if (cut_low) begin
					res.new_step = cfg.floor_val;
					res.status   = ST_FATAL;
				end else begin
					res.new_step = cut_val;
				end
			end
			default: begin
				res.action = ACT_KEEP;
			end
		endcase
	end

endmodule

// ===== test/adaptive_time_step_control_unit_tb.sv =====
module adaptive_time_step_control_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import atsc_pkg::*;

	localparam int FRAC           = 16;
	localparam int DRAIN_PAUSE    = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 200;
	localparam int NUM_PHASES     = 8;
	localparam int MAX_REPORTS    = 10;

	// Spare register slots and the two undefined step kinds
	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;
	localparam logic [1:0]       KIND_UND_A  = 2'd2;
	localparam logic [1:0]       KIND_UND_B  = 2'd3;

	logic              clk;
	logic              arst_n            = 1'b0;
	logic              psel              = 1'b0;
	logic              penable           = 1'b0;
	logic              pwrite            = 1'b0;
	logic [ADDR_W-1:0] paddr             = '0;
	data_t             pwdata            = '0;
	data_t             prdata;
	logic              pready;
	logic              item_valid        = 1'b0;
	logic              item_ready;
	logic              criterion_present = 1'b0;
	data_t             variation         = '0;
	data_t             keep_reference    = '0;
	data_t             rerun_limit       = '0;
	data_t             current_step      = '0;
	logic              last_criterion    = 1'b0;
	logic              result_valid;
	logic              result_ready      = 1'b0;
	data_t             new_step;
	logic              step_accepted;
	logic [2:0]        status;
	logic [1:0]        step_action;

	adaptive_time_step_control_unit #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_ready(item_ready),
		.criterion_present(criterion_present), .variation(variation),
		.keep_reference(keep_reference), .rerun_limit(rerun_limit),
		.current_step(current_step), .last_criterion(last_criterion),
		.result_valid(result_valid), .result_ready(result_ready),
		.new_step(new_step), .step_accepted(step_accepted),
		.status(status), .step_action(step_action)
	);

	// Shadow of the registers and of the worst grade held by the block
	cfg_t   regs;
	grade_t worst_seen;
	res_t   pending_steps[$];

	int errors     = 0;
	int n_items    = 0;
	int n_results  = 0;
	int n_writes   = 0;
	int burst_left = 0;
	bit gapless    = 0;
	int idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic note_error(input string msg);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endtask

	// floor(a * b / 2^FRAC), saturated to 32 bits
	function automatic data_t scale_step(input data_t a, input data_t b);
		logic [63:0] p;
		p = ({32'b0, a} * {32'b0, b}) >> FRAC;
		return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
	endfunction

	// Exact comparison against the band (1 + margin) around the keep reference
	function automatic grade_t grade_criterion(input data_t dx, input data_t r1,
			input data_t r2);
		logic [63:0] pm, dxb, rm, r1b;
		logic        frac;
		pm   = {32'b0, dx} * {32'b0, regs.margin};
		dxb  = (pm >> FRAC) + dx;
		rm   = {32'b0, r1} * {32'b0, regs.margin};
		r1b  = (rm >> FRAC) + r1;
		frac = rm[FRAC-1:0] != '0;
		if (dxb < r1)
			return GR_INC;
		if (dx < r1b || (dx == r1b && frac))
			return GR_KEEP;
		if (dx < r2)
			return GR_CUT;
		return GR_RERUN;
	endfunction

	// Reduce the step; returns 1 when the kind is defined and it stays at or above the floor
	function automatic bit shrink_step(input data_t s_in, output data_t s_out,
			output status_t st);
		data_t s;
		logic  under;
		s     = s_in;
		under = 1'b0;
		s_out = s_in;
		if (regs.kind == KIND_GEO) begin
			s = scale_step(s, regs.shrink);
		end else if (regs.kind == KIND_ARI) begin
			if (regs.shrink > s)
				under = 1'b1;
			else
				s = s - regs.shrink;
		end else begin
			st = ST_UNDEF;
			return 0;
		end
		if (under || s < regs.floor_val) begin
			s_out = regs.floor_val;
			st    = ST_MIN;
			return 0;
		end
		s_out = s;
		st    = ST_OK;
		return 1;
	endfunction

	// Fold one criterion into the worst grade; on a last item build the outcome
	function automatic bit predict_step_outcome(input logic pres, input data_t dx,
			input data_t r1, input data_t r2, input data_t stp, input logic lst,
			output res_t r);
		grade_t      g;
		data_t       s;
		status_t     st;
		bit          ok;
		logic [32:0] sum;
		r = '0;
		if (pres) begin
			g = grade_criterion(dx, r1, r2);
			if (g < worst_seen)
				worst_seen = g;
		end
		if (!lst)
			return 0;
		s          = stp;
		st         = ST_OK;
		r.accepted = 1'b1;
		r.action   = ACT_KEEP;
		case (worst_seen)
			GR_INC: begin
				r.action = ACT_INC;
				if (regs.kind == KIND_GEO) begin
					s = scale_step(s, regs.grow);
				end else if (regs.kind == KIND_ARI) begin
					sum = {1'b0, s} + {1'b0, regs.grow};
					s   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end else begin
					st         = ST_UNDEF;
					r.accepted = 1'b0;
				end
				if (st == ST_OK && s > regs.ceiling) begin
					s  = regs.ceiling;
					st = ST_MAX;
				end
			end
			GR_CUT: begin
				r.action   = ACT_CUT;
				ok         = shrink_step(s, s, st);
				r.accepted = (st == ST_OK || st == ST_MIN);
			end
			GR_RERUN: begin
				r.action = ACT_RERUN;
				ok       = shrink_step(s, s, st);
				if (!ok)
					st = ST_FATAL;
				r.accepted = 1'b0;
			end
			default: ;
		endcase
		r.new_step = s;
		r.status   = st;
		worst_seen = GR_NONE;
		return 1;
	endfunction

	function automatic data_t reg_value(input logic [IDX_W-1:0] idx);
		case (idx)
			REG_STEP_KIND:     return {30'b0, regs.kind};
			REG_GROW_AMOUNT:   return regs.grow;
			REG_SHRINK_AMOUNT: return regs.shrink;
			REG_BAND_MARGIN:   return regs.margin;
			REG_STEP_FLOOR:    return regs.floor_val;
			REG_STEP_CEILING:  return regs.ceiling;
			default:           return '0;
		endcase
	endfunction

	// Configuration port: setup then access cycle
	task automatic apb_write(input logic [IDX_W-1:0] idx, input data_t val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		n_writes++;
		case (idx)
			REG_STEP_KIND:     regs.kind      = val[1:0];
			REG_GROW_AMOUNT:   regs.grow      = val;
			REG_SHRINK_AMOUNT: regs.shrink    = val;
			REG_BAND_MARGIN:   regs.margin    = val;
			REG_STEP_FLOOR:    regs.floor_val = val;
			REG_STEP_CEILING:  regs.ceiling   = val;
			default: ;
		endcase
	endtask

	task automatic apb_read(input logic [IDX_W-1:0] idx, output data_t val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		val = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_regs();
		data_t v;
		for (int i = REG_STEP_KIND; i <= REG_STEP_CEILING; i++) begin
			apb_read(IDX_W'(i), v);
			if (v !== reg_value(IDX_W'(i)))
				note_error($sformatf("register %0d read %h, expected %h", i, v,
					reg_value(IDX_W'(i))));
		end
	endtask

	task automatic set_config(input logic [1:0] kind, input data_t grow,
			input data_t shrink, input data_t margin, input data_t flr, input data_t ceil);
		apb_write(REG_STEP_KIND, ($urandom & ~32'h3) | {30'b0, kind});
		apb_write(REG_GROW_AMOUNT, grow);
		apb_write(REG_SHRINK_AMOUNT, shrink);
		apb_write(REG_BAND_MARGIN, margin);
		apb_write(REG_STEP_FLOOR, flr);
		apb_write(REG_STEP_CEILING, ceil);
		check_regs();
	endtask

	// Hold the item channel idle until every outcome is back, then let the pipe empty
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		burst_left = 0;
		while (pending_steps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// Send one criterion item; items go in bursts with random gaps between them unless gapless is set
	task automatic send_item(input logic pres, input data_t dx, input data_t r1,
			input data_t r2, input data_t stp, input logic lst);
		res_t r;
		int   gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gapless ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		criterion_present <= pres;
		variation         <= dx;
		keep_reference    <= r1;
		rerun_limit       <= r2;
		current_step      <= stp;
		last_criterion    <= lst;
		item_valid        <= 1'b1;
		do @(posedge clk); while (!item_ready);
		n_items++;
		if (predict_step_outcome(pres, dx, r1, r2, stp, lst, r))
			pending_steps.push_back(r);
	endtask

	// Criterion values aimed at the band edges and the rerun limit
	task automatic gen_criterion(output data_t dx, output data_t r1, output data_t r2);
		logic [63:0] t;
		r1 = $urandom >> $urandom_range(0, 24);
		case ($urandom_range(0, 5))
			0: dx = r1 >> $urandom_range(1, 6);
			1: dx = r1 + $urandom_range(0, 64) - 32;
			2: begin
				t  = ({32'b0, r1} << FRAC) / (64'h1_0000 + regs.margin);
				dx = t[31:0] + $urandom_range(0, 2) - 1;
			end
			3: begin
				t  = r1 + (({32'b0, r1} * {32'b0, regs.margin}) >> FRAC);
				dx = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0] + $urandom_range(0, 2) - 1;
			end
			4: dx = r1 + (r1 >> $urandom_range(0, 4));
			default: begin
				dx = $urandom;
				r1 = $urandom;
			end
		endcase
		case ($urandom_range(0, 3))
			0: r2 = dx + $urandom_range(0, 2) - 1;
			1: r2 = dx + ($urandom >> $urandom_range(4, 28));
			2: r2 = dx >> 1;
			default: r2 = $urandom;
		endcase
	endtask

	// Receiver: always ready, random, periodic and long stalls in turn
	initial begin : result_sink
		int unsigned cyc  = 0;
		int unsigned hold = 0;
		forever begin
			@(negedge clk);
			cyc++;
			case ((cyc >> 8) % 4)
				0: result_ready <= 1'b1;
				1: result_ready <= $urandom_range(0, 1);
				2: result_ready <= (cyc % 9) >= 4;
				default: begin
					if (hold == 0 && $urandom_range(0, 7) == 0)
						hold = $urandom_range(1, 15);
					if (hold > 0) begin
						hold--;
						result_ready <= 1'b0;
					end else begin
						result_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Compare each result transaction with the oldest predicted outcome
	always @(posedge clk) begin : result_check
		res_t e;
		if (arst_n && result_valid && result_ready) begin
			if (pending_steps.size() == 0) begin
				note_error($sformatf("unexpected result step=%h acc=%b st=%0d act=%0d",
					new_step, step_accepted, status, step_action));
			end else begin
				e = pending_steps.pop_front();
				n_results++;
				if (new_step !== e.new_step || step_accepted !== e.accepted ||
						status !== e.status || step_action !== e.action)
					note_error($sformatf(
						"step %h/%h acc %b/%b status %0d/%0d action %0d/%0d (got/exp)",
						new_step, e.new_step, step_accepted, e.accepted,
						status, e.status, step_action, e.action));
			end
		end
	end

	// Abort when no transaction of any kind moves for too long
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || psel) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic test_reset_values();
		check_regs();
	endtask

	// One step per grade, empty items and field extremes under the reset settings
	task automatic test_grades();
		send_item(1'b1, 32'h1000, 32'h10000, 32'h20000, 32'h10000, 1'b1);
		send_item(1'b1, 32'h10000, 32'h10000, 32'h20000, 32'h10000, 1'b1);
		send_item(1'b1, 32'h18000, 32'h10000, 32'h20000, 32'h10000, 1'b1);
		send_item(1'b1, 32'h20000, 32'h10000, 32'h20000, 32'h10000, 1'b1);
		send_item(1'b0, $urandom, $urandom, $urandom, 32'h30000, 1'b1);
		send_item(1'b1, 32'h1000, 32'h10000, 32'h20000, $urandom, 1'b0);
		send_item(1'b0, 32'h0, 32'h0, 32'h0, $urandom, 1'b0);
		send_item(1'b1, 32'h18000, 32'h10000, 32'h20000, 32'h40000, 1'b1);
		send_item(1'b1, '1, '1, '1, '1, 1'b1);
		send_item(1'b1, '0, '0, '0, '0, 1'b1);
		send_item(1'b1, 32'h0, 32'h10000, 32'h20000, '1, 1'b1);
		drain();
	endtask

	// Exact lower and upper edges of the keep band with a margin of one half
	task automatic test_band_edges();
		set_config(KIND_GEO, 32'h14000, 32'h8000, 32'h8000, 32'h1, '1);
		send_item(1'b1, 32'h20000, 32'h30000, '1, 32'h10000, 1'b1);
		send_item(1'b1, 32'h1FFFF, 32'h30000, '1, 32'h10000, 1'b1);
		send_item(1'b1, 32'h18001, 32'h10001, '1, 32'h10000, 1'b1);
		send_item(1'b1, 32'h18002, 32'h10001, '1, 32'h10000, 1'b1);
		drain();
	endtask

	// Ceiling on increase, floor on cut, and a fatal rerun at the floor
	task automatic test_clamps();
		set_config(KIND_GEO, 32'h14000, 32'h8000, 32'h1999, 32'h8000, 32'h20000);
		send_item(1'b1, 32'h0, 32'h10000, 32'h20000, 32'h20000, 1'b1);
		send_item(1'b1, 32'h18000, 32'h10000, 32'h20000, 32'hC000, 1'b1);
		send_item(1'b1, 32'h30000, 32'h10000, 32'h20000, 32'hC000, 1'b1);
		drain();
	endtask

	// Arithmetic underflow, saturation beyond the ceiling and a plain rerun
	task automatic test_arith();
		set_config(KIND_ARI, 32'h20000, 32'h30000, 32'h1999, 32'h1, 32'hFFFF_F000);
		send_item(1'b1, 32'h18000, 32'h10000, 32'h20000, 32'h20000, 1'b1);
		send_item(1'b1, 32'h0, 32'h10000, 32'h20000, 32'hFFFF_0000, 1'b1);
		send_item(1'b1, 32'h30000, 32'h10000, 32'h20000, 32'h50000, 1'b1);
		drain();
	endtask

	// Undefined kinds, and writes to the unused register slots
	task automatic test_undef_kind();
		set_config(KIND_UND_A, 32'h14000, 32'h8000, 32'h1999, 32'h1, '1);
		apb_write(REG_SPARE_A, $urandom);
		apb_write(REG_SPARE_B, $urandom);
		check_regs();
		send_item(1'b1, 32'h0, 32'h10000, 32'h20000, 32'h10000, 1'b1);
		send_item(1'b1, 32'h18000, 32'h10000, 32'h20000, 32'h10000, 1'b1);
		send_item(1'b1, 32'h30000, 32'h10000, 32'h20000, 32'h10000, 1'b1);
		drain();
		set_config(KIND_UND_B, 32'h14000, 32'h8000, 32'h1999, 32'h1, '1);
		send_item(1'b1, 32'h0, 32'h10000, 32'h20000, 32'h10000, 1'b1);
		drain();
	endtask

	// Mostly well-formed steps of random length, some noise, one setting per phase
	task automatic test_random_phases();
		logic [1:0] kinds[NUM_PHASES] = '{KIND_GEO, KIND_ARI, KIND_GEO, KIND_ARI,
			KIND_UND_A, KIND_GEO, KIND_ARI, KIND_UND_B};
		data_t dx, r1, r2;
		data_t grow, shrink, margin, flr, ceil;
		int    cnt, n;
		for (int p = 0; p < NUM_PHASES; p++) begin
			grow   = (p == 3) ? 32'h0 : (p == 5) ? '1 : $urandom_range(32'h10000, 32'h40000);
			shrink = (p == 2) ? 32'h0 : (p == 6) ? '1 : $urandom_range(32'h1000, 32'hFFFF);
			margin = (p == 1) ? 32'h0 : (p == 4) ? '1 : $urandom_range(0, 32'h10000);
			flr    = (p == 0) ? 32'h0 : (p == 6) ? '1 : $urandom >> $urandom_range(8, 24);
			ceil   = (p == 7) ? 32'h0 : (p == 2) ? '1 : 32'hFFFF_FFFF >> $urandom_range(0, 12);
			set_config(kinds[p], grow, shrink, margin, flr, ceil);
			gapless = (p % 3) == 1;
			cnt = 0;
			while (cnt < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 12) begin
					send_item($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
						$urandom_range(0, 1));
					cnt++;
				end else begin
					n = $urandom_range(1, 5);
					for (int k = 0; k < n; k++) begin
						gen_criterion(dx, r1, r2);
						send_item($urandom_range(0, 9) != 0, dx, r1, r2,
							$urandom >> $urandom_range(0, 20), k == n - 1);
						cnt++;
					end
				end
			end
			drain();
		end
		gapless = 0;
	endtask

	initial begin
		regs = '{kind: KIND_GEO, grow: 32'd81920, shrink: 32'd32768, margin: 32'd6554,
			floor_val: 32'd1, ceiling: 32'hFFFF_FFFF};
		worst_seen = GR_NONE;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_values();
		test_grades();
		test_band_edges();
		test_clamps();
		test_arith();
		test_undef_kind();
		test_random_phases();

		drain();
		if (pending_steps.size() != 0)
			note_error($sformatf("%0d predicted outcomes never arrived", pending_steps.size()));
		$display("Covered %0d criterion items, %0d step outcomes, %0d register writes",
			n_items, n_results, n_writes);
		$display("across geometric, arithmetic and undefined kinds with extreme limits");
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
